### sv/pit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

   // Default coordinate width of one vertex or point component.
   localparam int COORD_BITS_DEF = 16;

   // Pipeline layout: dot-product section, split wide multiplier, cross terms, result.
   localparam int DOT_STAGES = 3;
   localparam int MUL_STAGES = 2;
   localparam int CROSS_STG  = DOT_STAGES + MUL_STAGES;
   localparam int OUT_STG    = CROSS_STG + 1;
   localparam int NUM_STAGES = OUT_STG + 1;

endpackage

`default_nettype wire

### sv/pit_dot.sv
`timescale 1ns / 1ps
`default_nettype none

module pit_dot #(
   parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic [pit_pkg::DOT_STAGES-1:0] stage_en,
   input  logic signed [COORD_BITS-1:0]   v0_in [3],
   input  logic signed [COORD_BITS-1:0]   v1_in [3],
   input  logic signed [COORD_BITS-1:0]   v2_in [3],
   input  logic signed [COORD_BITS-1:0]   pt_in [3],
   output logic signed [2*COORD_BITS+2:0] dot_a,
   output logic signed [2*COORD_BITS+2:0] dot_b,
   output logic signed [2*COORD_BITS+2:0] dot_c,
   output logic signed [2*COORD_BITS+2:0] dot_d,
   output logic signed [2*COORD_BITS+2:0] dot_e
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int DOT_BITS  = 2 * COORD_BITS + 3;

   logic signed [DIFF_BITS-1:0] e1_ff [3];
   logic signed [DIFF_BITS-1:0] e2_ff [3];
   logic signed [DIFF_BITS-1:0] w_ff [3];

   logic signed [PROD_BITS-1:0] paa_ff [3];
   logic signed [PROD_BITS-1:0] pab_ff [3];
   logic signed [PROD_BITS-1:0] pbb_ff [3];
   logic signed [PROD_BITS-1:0] pwa_ff [3];
   logic signed [PROD_BITS-1:0] pwb_ff [3];

   logic signed [DOT_BITS-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;

   // Edge vectors and point offset, all taken from the first vertex.
   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= DIFF_BITS'(v1_in[i]) - DIFF_BITS'(v0_in[i]);
            e2_ff[i] <= DIFF_BITS'(v2_in[i]) - DIFF_BITS'(v0_in[i]);
            w_ff[i]  <= DIFF_BITS'(pt_in[i]) - DIFF_BITS'(v0_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         for (int i = 0; i < 3; i++) begin
            paa_ff[i] <= e1_ff[i] * e1_ff[i];
            pab_ff[i] <= e1_ff[i] * e2_ff[i];
            pbb_ff[i] <= e2_ff[i] * e2_ff[i];
            pwa_ff[i] <= w_ff[i] * e1_ff[i];
            pwb_ff[i] <= w_ff[i] * e2_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         a_ff <= DOT_BITS'(paa_ff[0]) + DOT_BITS'(paa_ff[1]) + DOT_BITS'(paa_ff[2]);
         b_ff <= DOT_BITS'(pab_ff[0]) + DOT_BITS'(pab_ff[1]) + DOT_BITS'(pab_ff[2]);
         c_ff <= DOT_BITS'(pbb_ff[0]) + DOT_BITS'(pbb_ff[1]) + DOT_BITS'(pbb_ff[2]);
         d_ff <= DOT_BITS'(pwa_ff[0]) + DOT_BITS'(pwa_ff[1]) + DOT_BITS'(pwa_ff[2]);
         e_ff <= DOT_BITS'(pwb_ff[0]) + DOT_BITS'(pwb_ff[1]) + DOT_BITS'(pwb_ff[2]);
      end
   end

   assign dot_a = a_ff;
   assign dot_b = b_ff;
   assign dot_c = c_ff;
   assign dot_d = d_ff;
   assign dot_e = e_ff;

endmodule

`default_nettype wire

### sv/pit_wmul.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed multiplier split into half-width partial products, summed one stage later.
module pit_wmul #(
   parameter int OPND_BITS = 2 * pit_pkg::COORD_BITS_DEF + 3
) (
   input  logic                           clock,
   input  logic [pit_pkg::MUL_STAGES-1:0] stage_en,
   input  logic signed [OPND_BITS-1:0]    a_in,
   input  logic signed [OPND_BITS-1:0]    b_in,
   output logic signed [2*OPND_BITS-1:0]  prod_out
);

   localparam int LO_BITS   = OPND_BITS / 2;
   localparam int HI_BITS   = OPND_BITS - LO_BITS;
   localparam int PROD_BITS = 2 * OPND_BITS;

   logic signed [LO_BITS:0]   a_lo, b_lo;
   logic signed [HI_BITS-1:0] a_hi, b_hi;

   logic signed [2*LO_BITS+1:0]       ll_ff;
   logic signed [LO_BITS+HI_BITS:0]   lh_ff;
   logic signed [LO_BITS+HI_BITS:0]   hl_ff;
   logic signed [2*HI_BITS-1:0]       hh_ff;
   logic signed [PROD_BITS-1:0]       prod_ff;

   // The low halves are unsigned; a zero sign bit lets them join signed products.
   assign a_lo = $signed({1'b0, a_in[LO_BITS-1:0]});
   assign b_lo = $signed({1'b0, b_in[LO_BITS-1:0]});
   assign a_hi = a_in[OPND_BITS-1:LO_BITS];
   assign b_hi = b_in[OPND_BITS-1:LO_BITS];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         ll_ff <= a_lo * b_lo;
         lh_ff <= a_lo * b_hi;
         hl_ff <= a_hi * b_lo;
         hh_ff <= a_hi * b_hi;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         prod_ff <= PROD_BITS'(ll_ff)
                    + (PROD_BITS'(lh_ff) <<< LO_BITS)
                    + (PROD_BITS'(hl_ff) <<< LO_BITS)
                    + (PROD_BITS'(hh_ff) <<< (2 * LO_BITS));
      end
   end

   assign prod_out = prod_ff;

endmodule

`default_nettype wire

### sv/point_in_triangle_test_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Barycentric point-in-triangle test in 3D with exact integer arithmetic. Each item carries
// three vertices and a query point; the result item is 1 when the point's projection onto
// the triangle's plane lies inside the triangle (edges from the first vertex count as
// inside, the edge opposite it as outside, a degenerate triangle never contains a point).
// The block is a seven-stage pipeline: three stages form the edge vectors and the five dot
// products, two stages run six split-operand wide multipliers, one forms the cross terms
// and the last holds the result. It takes one item per clock unless a stall on the result
// side has filled every stage; such a stall fills empty stages first and then holds the
// whole pipeline. COORD_BITS may be set from 8 to 24.
module point_in_triangle_test_top #(
   parameter int COORD_BITS = pit_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_v0_x,
   input  logic signed [COORD_BITS-1:0] req_v0_y,
   input  logic signed [COORD_BITS-1:0] req_v0_z,
   input  logic signed [COORD_BITS-1:0] req_v1_x,
   input  logic signed [COORD_BITS-1:0] req_v1_y,
   input  logic signed [COORD_BITS-1:0] req_v1_z,
   input  logic signed [COORD_BITS-1:0] req_v2_x,
   input  logic signed [COORD_BITS-1:0] req_v2_y,
   input  logic signed [COORD_BITS-1:0] req_v2_z,
   input  logic signed [COORD_BITS-1:0] req_pt_x,
   input  logic signed [COORD_BITS-1:0] req_pt_y,
   input  logic signed [COORD_BITS-1:0] req_pt_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_inside_res
);

   localparam int DOT_BITS  = 2 * COORD_BITS + 3;
   localparam int PROD_BITS = 2 * DOT_BITS;
   localparam int XBITS     = PROD_BITS + 1;
   localparam int ZBITS     = PROD_BITS + 3;

   logic [pit_pkg::NUM_STAGES-1:0] vld_ff;
   logic [pit_pkg::NUM_STAGES-1:0] stage_en;

   logic signed [COORD_BITS-1:0] v0_arr [3];
   logic signed [COORD_BITS-1:0] v1_arr [3];
   logic signed [COORD_BITS-1:0] v2_arr [3];
   logic signed [COORD_BITS-1:0] pt_arr [3];

   logic signed [DOT_BITS-1:0]  dot_a, dot_b, dot_c, dot_d, dot_e;
   logic signed [PROD_BITS-1:0] p_ac, p_bb, p_dc, p_eb, p_ea, p_db;

   logic signed [XBITS-1:0] area_ff, x_ff, y_ff;
   logic signed [ZBITS-1:0] z_val;
   logic                    inside_ff;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      stage_en[pit_pkg::OUT_STG] = ~vld_ff[pit_pkg::OUT_STG] | rsp_ready;
      for (int k = pit_pkg::OUT_STG - 1; k >= 0; k--) begin
         stage_en[k] = ~vld_ff[k] | stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < pit_pkg::NUM_STAGES; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_ready = stage_en[0];

   always_comb begin
      v0_arr[0] = req_v0_x;
      v0_arr[1] = req_v0_y;
      v0_arr[2] = req_v0_z;
      v1_arr[0] = req_v1_x;
      v1_arr[1] = req_v1_y;
      v1_arr[2] = req_v1_z;
      v2_arr[0] = req_v2_x;
      v2_arr[1] = req_v2_y;
      v2_arr[2] = req_v2_z;
      pt_arr[0] = req_pt_x;
      pt_arr[1] = req_pt_y;
      pt_arr[2] = req_pt_z;
   end

   pit_dot #(
      .COORD_BITS (COORD_BITS)
   ) u_dot (
      .clock    (clock),
      .stage_en (stage_en[pit_pkg::DOT_STAGES-1:0]),
      .v0_in    (v0_arr),
      .v1_in    (v1_arr),
      .v2_in    (v2_arr),
      .pt_in    (pt_arr),
      .dot_a    (dot_a),
      .dot_b    (dot_b),
      .dot_c    (dot_c),
      .dot_d    (dot_d),
      .dot_e    (dot_e)
   );

   pit_wmul #(.OPND_BITS (DOT_BITS)) u_mul_ac (
      .clock    (clock),
      .stage_en (stage_en[pit_pkg::DOT_STAGES +: pit_pkg::MUL_STAGES]),
      .a_in     (dot_a),
      .b_in     (dot_c),
      .prod_out (p_ac)
   );

   pit_wmul #(.OPND_BITS (DOT_BITS)) u_mul_bb (
      .clock    (clock),
      .stage_en (stage_en[pit_pkg::DOT_STAGES +: pit_pkg::MUL_STAGES]),
      .a_in     (dot_b),
      .b_in     (dot_b),
      .prod_out (p_bb)
   );

   pit_wmul #(.OPND_BITS (DOT_BITS)) u_mul_dc (
      .clock    (clock),
      .stage_en (stage_en[pit_pkg::DOT_STAGES +: pit_pkg::MUL_STAGES]),
      .a_in     (dot_d),
      .b_in     (dot_c),
      .prod_out (p_dc)
   );

   pit_wmul #(.OPND_BITS (DOT_BITS)) u_mul_eb (
      .clock    (clock),
      .stage_en (stage_en[pit_pkg::DOT_STAGES +: pit_pkg::MUL_STAGES]),
      .a_in     (dot_e),
      .b_in     (dot_b),
      .prod_out (p_eb)
   );

   pit_wmul #(.OPND_BITS (DOT_BITS)) u_mul_ea (
      .clock    (clock),
      .stage_en (stage_en[pit_pkg::DOT_STAGES +: pit_pkg::MUL_STAGES]),
      .a_in     (dot_e),
      .b_in     (dot_a),
      .prod_out (p_ea)
   );

   pit_wmul #(.OPND_BITS (DOT_BITS)) u_mul_db (
      .clock    (clock),
      .stage_en (stage_en[pit_pkg::DOT_STAGES +: pit_pkg::MUL_STAGES]),
      .a_in     (dot_d),
      .b_in     (dot_b),
      .prod_out (p_db)
   );

   always_ff @(posedge clock) begin
      if (stage_en[pit_pkg::CROSS_STG]) begin
         area_ff <= XBITS'(p_ac) - XBITS'(p_bb);
         x_ff    <= XBITS'(p_dc) - XBITS'(p_eb);
         y_ff    <= XBITS'(p_ea) - XBITS'(p_db);
      end
   end

   assign z_val = ZBITS'(x_ff) + ZBITS'(y_ff) - ZBITS'(area_ff);

   always_ff @(posedge clock) begin
      if (stage_en[pit_pkg::OUT_STG]) begin
         inside_ff <= z_val[ZBITS-1] & ~x_ff[XBITS-1] & ~y_ff[XBITS-1];
      end
   end

   assign rsp_valid      = vld_ff[pit_pkg::OUT_STG];
   assign rsp_inside_res = inside_ff;

   // Any empty stage must leave room for a new item.
   a_ready_on_bubble : assert property (@(posedge clock) disable iff (reset)
      !(&vld_ff) |-> req_ready)
      else $error("input stalled while the pipeline has an empty stage");

   // A result taken downstream frees the whole pipeline to advance.
   a_ready_on_drain : assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while the result side is draining");

   // A degenerate triangle never reports a point inside.
   a_degenerate_out : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[pit_pkg::CROSS_STG] && stage_en[pit_pkg::OUT_STG] && area_ff == '0)
      |=> !rsp_inside_res)
      else $error("degenerate triangle reported a point inside");

   // A negative first barycentric term always means outside.
   a_negative_x_out : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[pit_pkg::CROSS_STG] && stage_en[pit_pkg::OUT_STG] && x_ff[XBITS-1])
      |=> !rsp_inside_res)
      else $error("negative x term reported a point inside");

endmodule

`default_nettype wire
